[hw/rtl/ispu_pkg.sv]
package ispu_pkg;
    localparam logic [1:0] KIND_INSERT   = 2'd0;
    localparam logic [1:0] KIND_ERASE    = 2'd1;
    localparam logic [1:0] KIND_CONTAINS = 2'd2;
    localparam logic [1:0] KIND_RANK     = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_RANK = 2'd2;

    typedef struct packed {
        logic        changed;
        logic        member;
        logic [31:0] element;
        logic [32:0] set_size;
        logic [1:0]  status;
    } t_result;
endpackage

[hw/rtl/ispu_store.sv]
// Interval store: one memory for each bound, one read port and one write port each.
module ispu_store #(
    parameter int MAX_INTERVALS = 16,
    parameter int AW = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wlow,
    input  logic [31:0]   i_whigh,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rlow,
    output logic [31:0]   o_rhigh
);
    logic [31:0] r_low  [MAX_INTERVALS];
    logic [31:0] r_high [MAX_INTERVALS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_low[i_waddr]  <= i_wlow;
            r_high[i_waddr] <= i_whigh;
        end
        o_rlow  <= r_low[i_raddr];
        o_rhigh <= r_high[i_raddr];
    end
endmodule

[hw/rtl/interval_set_point_update_core.sv]
// Channel | Direction | Beat fields
// in      | input     | i_kind, i_value, i_rank
// out     | output    | o_changed, o_member, o_element, o_set_size, o_status
//
// One request at a time. The scan reads one stored interval per pass through S_RD and S_CHK
// by way of the registered read port, and a shift moves one entry per pass through S_MVRD and
// S_MVWR. The scan stops at the insertion point, and the shift runs between that point and
// the last stored interval.
// Synchronous reset empties the set; stored bounds are only read below the count.
// o_stall stays high from the input beat until the result beat has left.
module interval_set_point_update_core #(
    parameter int MAX_INTERVALS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic signed [31:0] i_value,
    input  logic [31:0] i_rank,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_changed,
    output logic        o_member,
    output logic signed [31:0] o_element,
    output logic [32:0] o_set_size,
    output logic [1:0]  o_status
);
    import ispu_pkg::*;

    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_INTERVALS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_ACT   = 3'd3;
    localparam logic [2:0] S_MVRD  = 3'd4;
    localparam logic [2:0] S_MVWR  = 3'd5;
    localparam logic [2:0] S_WR    = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]  r_state;
    logic [1:0]  r_kind;
    logic signed [32:0] r_x;
    logic [32:0] r_rank;
    logic [CW-1:0] r_cnt, r_p, r_k, r_end;
    logic [32:0] r_total;
    // previous interval (p-1) and next interval (p) as seen by the scan
    logic        r_hv, r_nv;
    logic signed [32:0] r_plo, r_phi, r_nlo, r_nhi;
    // shift direction: 1 opens a slot (moves up), 0 closes one (moves down)
    logic        r_up;
    logic        r_wr, r_w2;
    logic [AW-1:0] r_wa, r_wa2;
    logic [31:0] r_wlo, r_whi, r_wlo2, r_whi2;
    logic        r_ov;
    t_result     r_res;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wlo, whi, rlo, rhi;

    ispu_store #(.MAX_INTERVALS(MAX_INTERVALS), .AW(AW)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wlow(wlo), .i_whigh(whi),
        .i_raddr(raddr), .o_rlow(rlo), .o_rhigh(rhi)
    );

    logic signed [32:0] clo, chi, xm1, xp1, elem_sum;
    logic [32:0] span;
    logic prev_in, prev_adj, up_adj, is_full;
    assign clo  = {rlo[31], rlo};
    assign chi  = {rhi[31], rhi};
    assign xm1  = r_x - 33'sd1;
    assign xp1  = r_x + 33'sd1;
    assign span = $unsigned(chi - clo) + 33'd1;
    assign elem_sum = clo + $signed(r_rank);
    // Neighbor tests run at 33 bits, so the extreme values never wrap.
    assign prev_in  = r_hv && (r_phi >= r_x);
    assign prev_adj = r_hv && (r_phi == xm1);
    assign up_adj   = r_nv && (r_nlo == xp1);
    assign is_full  = (r_cnt >= CAP);

    always_comb begin
        we = 1'b0; waddr = r_wa; wlo = r_wlo; whi = r_whi;
        raddr = r_k[AW-1:0];
        if (r_state == S_MVWR) begin
            we = 1'b1;
            wlo = rlo; whi = rhi;
            waddr = r_up ? AW'(r_k + 1'b1) : AW'(r_k - 1'b1);
        end else if (r_state == S_WR) begin
            we = 1'b1;
        end
    end

    assign o_stall   = (r_state != S_IDLE) || r_ov;
    assign o_valid   = r_ov;
    assign o_changed = r_res.changed;
    assign o_member  = r_res.member;
    assign o_element = r_res.element;
    assign o_set_size = r_res.set_size;
    assign o_status  = r_res.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == S_DONE) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !r_ov) begin
                        r_kind <= i_kind;
                        r_x    <= {i_value[31], i_value};
                        r_rank <= {1'b0, i_rank};
                        r_k    <= '0;
                        r_hv   <= 1'b0;
                        r_nv   <= 1'b0;
                        r_w2   <= 1'b0;
                        r_res  <= '{changed: 1'b0, member: 1'b0, element: 32'd0,
                                    set_size: r_total, status: ST_OK};
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_kind == KIND_RANK && r_rank >= r_total) begin
                        r_res.status <= ST_RANK;
                        r_state <= S_DONE;
                    end else if (r_k >= r_cnt) begin
                        r_p <= r_k;
                        r_state <= S_ACT;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_kind == KIND_RANK) begin
                        if (r_rank < span) begin
                            r_res.element <= elem_sum[31:0];
                            r_state <= S_DONE;
                        end else begin
                            r_rank <= r_rank - span;
                            r_k <= r_k + 1'b1;
                            r_state <= S_RD;
                        end
                    end else if (clo <= r_x) begin
                        r_hv  <= 1'b1;
                        r_plo <= clo;
                        r_phi <= chi;
                        r_k   <= r_k + 1'b1;
                        r_state <= S_RD;
                    end else begin
                        // First interval above the value: keep it as the upper neighbor.
                        r_nv  <= 1'b1;
                        r_nlo <= clo;
                        r_nhi <= chi;
                        r_p   <= r_k;
                        r_state <= S_ACT;
                    end
                end
                S_ACT: begin
                    case (r_kind)
                        KIND_CONTAINS: begin
                            r_res.member <= prev_in;
                            r_state <= S_DONE;
                        end
                        KIND_INSERT: begin
                            if (prev_in) begin
                                r_state <= S_DONE;
                            end else if (prev_adj && up_adj) begin
                                // Join p-1 and p: close slot p, then write the joined interval into p-1.
                                r_wa <= AW'(r_p - 1'b1);
                                r_wlo <= r_plo[31:0]; r_whi <= r_nhi[31:0];
                                r_wr <= 1'b1;
                                r_up <= 1'b0; r_k <= r_p + 1'b1; r_end <= r_cnt - 1'b1;
                                r_cnt <= r_cnt - 1'b1;
                                r_res.changed <= 1'b1;
                                r_total <= r_total + 1'b1;
                                r_res.set_size <= r_total + 1'b1;
                                r_state <= (r_p + 1'b1 == r_cnt) ? S_WR : S_MVRD;
                            end else if (prev_adj) begin
                                r_wa <= AW'(r_p - 1'b1);
                                r_wlo <= r_plo[31:0]; r_whi <= r_x[31:0];
                                r_res.changed <= 1'b1;
                                r_total <= r_total + 1'b1;
                                r_res.set_size <= r_total + 1'b1;
                                r_state <= S_WR;
                            end else if (up_adj) begin
                                r_wa <= AW'(r_p);
                                r_wlo <= r_x[31:0]; r_whi <= r_nhi[31:0];
                                r_res.changed <= 1'b1;
                                r_total <= r_total + 1'b1;
                                r_res.set_size <= r_total + 1'b1;
                                r_state <= S_WR;
                            end else if (is_full) begin
                                r_res.status <= ST_FULL;
                                r_state <= S_DONE;
                            end else begin
                                // Open slot p for a single-value interval.
                                r_wa <= AW'(r_p);
                                r_wlo <= r_x[31:0]; r_whi <= r_x[31:0];
                                r_wr <= 1'b1;
                                r_up <= 1'b1; r_k <= r_cnt - 1'b1; r_end <= r_p;
                                r_cnt <= r_cnt + 1'b1;
                                r_res.changed <= 1'b1;
                                r_total <= r_total + 1'b1;
                                r_res.set_size <= r_total + 1'b1;
                                r_state <= (r_p == r_cnt) ? S_WR : S_MVRD;
                            end
                        end
                        KIND_ERASE: begin
                            if (!prev_in) begin
                                r_state <= S_DONE;
                            end else if (r_phi == r_x && r_plo == r_x) begin
                                // Drop interval p-1 by closing its slot.
                                r_wr <= 1'b0;
                                r_up <= 1'b0; r_k <= r_p; r_end <= r_cnt - 1'b1;
                                r_cnt <= r_cnt - 1'b1;
                                r_res.changed <= 1'b1;
                                r_total <= r_total - 1'b1;
                                r_res.set_size <= r_total - 1'b1;
                                r_state <= (r_p == r_cnt) ? S_DONE : S_MVRD;
                            end else if (r_phi == r_x || r_plo == r_x) begin
                                r_wa <= AW'(r_p - 1'b1);
                                r_wlo <= (r_plo == r_x) ? xp1[31:0] : r_plo[31:0];
                                r_whi <= (r_phi == r_x) ? xm1[31:0] : r_phi[31:0];
                                r_res.changed <= 1'b1;
                                r_total <= r_total - 1'b1;
                                r_res.set_size <= r_total - 1'b1;
                                r_state <= S_WR;
                            end else if (is_full) begin
                                r_res.status <= ST_FULL;
                                r_state <= S_DONE;
                            end else begin
                                // Split: open slot p for the upper part, then trim p-1.
                                r_wa <= AW'(r_p);
                                r_wlo <= xp1[31:0]; r_whi <= r_phi[31:0];
                                r_wa2 <= AW'(r_p - 1'b1);
                                r_wlo2 <= r_plo[31:0]; r_whi2 <= xm1[31:0];
                                r_wr <= 1'b1; r_w2 <= 1'b1;
                                r_up <= 1'b1; r_k <= r_cnt - 1'b1; r_end <= r_p;
                                r_cnt <= r_cnt + 1'b1;
                                r_res.changed <= 1'b1;
                                r_total <= r_total - 1'b1;
                                r_res.set_size <= r_total - 1'b1;
                                r_state <= (r_p == r_cnt) ? S_WR : S_MVRD;
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_MVRD: r_state <= S_MVWR;
                S_MVWR: begin
                    if (r_k == r_end) begin
                        r_state <= r_wr ? S_WR : S_DONE;
                    end else begin
                        r_k <= r_up ? r_k - 1'b1 : r_k + 1'b1;
                        r_state <= S_MVRD;
                    end
                end
                S_WR: begin
                    if (r_w2) begin
                        r_wa <= r_wa2; r_wlo <= r_wlo2; r_whi <= r_whi2;
                        r_w2 <= 1'b0;
                        r_state <= S_WR;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[bench/tb_interval_set_point_update_core.sv]
`timescale 1ns / 1ps

module tb_interval_set_point_update_core;
    import ispu_pkg::*;

    localparam int CAP = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_kind;
    logic signed [31:0] i_value;
    logic [31:0] i_rank;
    logic        o_valid;
    logic        i_stall;
    logic        o_changed;
    logic        o_member;
    logic signed [31:0] o_element;
    logic [32:0] o_set_size;
    logic [1:0]  o_status;

    interval_set_point_update_core #(.MAX_INTERVALS(CAP)) dut (.*);

    // Shadow copy of the interval store, kept in 64-bit signed terms.
    longint  span_lo [CAP];
    longint  span_hi [CAP];
    int      span_cnt;
    longint  elem_cnt;

    t_result pending_results[$];
    int      mismatch_cnt;
    int      failed;
    longint  cycle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 2000000) begin
            $display("tb_interval_set_point_update_core: done, errors");
            $finish;
        end
    end

    function automatic int spans_at_or_below(longint x);
        int p;
        p = 0;
        while (p < span_cnt && span_lo[p] <= x) p++;
        return p;
    endfunction

    function automatic void open_gap(int at);
        for (int k = span_cnt; k > at; k--) begin
            span_lo[k] = span_lo[k-1];
            span_hi[k] = span_hi[k-1];
        end
        span_cnt++;
    endfunction

    function automatic void close_gap(int at);
        for (int k = at; k + 1 < span_cnt; k++) begin
            span_lo[k] = span_lo[k+1];
            span_hi[k] = span_hi[k+1];
        end
        span_cnt--;
    endfunction

    function automatic t_result predict_request(logic [1:0] kind, logic signed [31:0] v,
                                                logic [31:0] r);
        t_result res;
        longint x;
        longint rr;
        longint w;
        int p;
        int q;
        x = longint'(v);
        res = '0;
        p = spans_at_or_below(x);
        case (kind)
            KIND_INSERT: begin
                if (p > 0 && span_hi[p-1] >= x) begin
                end else if (p > 0 && span_hi[p-1] == x - 1) begin
                    span_hi[p-1] = x;
                    if (p < span_cnt && span_lo[p] == x + 1) begin
                        span_hi[p-1] = span_hi[p];
                        close_gap(p);
                    end
                    res.changed = 1'b1;
                end else if (p < span_cnt && span_lo[p] == x + 1) begin
                    span_lo[p] = x;
                    res.changed = 1'b1;
                end else if (span_cnt >= CAP) begin
                    res.status = ST_FULL;
                end else begin
                    open_gap(p);
                    span_lo[p] = x;
                    span_hi[p] = x;
                    res.changed = 1'b1;
                end
                if (res.changed) elem_cnt++;
            end
            KIND_ERASE: begin
                if (!(p == 0 || span_hi[p-1] < x)) begin
                    q = p - 1;
                    res.changed = 1'b1;
                    if (span_hi[q] == x) begin
                        span_hi[q] = x - 1;
                        if (span_lo[q] > span_hi[q]) close_gap(q);
                    end else if (span_lo[q] == x) begin
                        span_lo[q] = x + 1;
                    end else if (span_cnt >= CAP) begin
                        res.status = ST_FULL;
                        res.changed = 1'b0;
                    end else begin
                        open_gap(p);
                        span_lo[p] = x + 1;
                        span_hi[p] = span_hi[q];
                        span_hi[q] = x - 1;
                    end
                    if (res.changed) elem_cnt--;
                end
            end
            KIND_CONTAINS: res.member = (p > 0 && span_hi[p-1] >= x);
            default: begin
                rr = longint'(r);
                if (rr >= elem_cnt) begin
                    res.status = ST_RANK;
                end else begin
                    for (int k = 0; k < span_cnt; k++) begin
                        w = span_hi[k] - span_lo[k] + 1;
                        if (rr < w) begin
                            res.element = 32'(span_lo[k] + rr);
                            break;
                        end
                        rr -= w;
                    end
                end
            end
        endcase
        res.set_size = 33'(elem_cnt);
        return res;
    endfunction

    // Valid stays high after a beat when the next one follows with no idle cycle.
    task automatic send_request(logic [1:0] kind, logic signed [31:0] v, logic [31:0] r);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_value <= v;
        i_rank  <= r;
        do @(posedge i_clk); while (o_stall);
        pending_results = {pending_results, predict_request(kind, v, r)};
    endtask

    // Receiver: draws a stall length per beat.
    initial begin
        int hold;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                hold = $urandom_range(0, 4);
                if (hold != 0) begin
                    i_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_changed, o_member, o_element, o_set_size, o_status};
            if (pending_results.size() == 0) begin
                failed = 1;
                if (mismatch_cnt < 10) $display("unexpected result beat %p", got);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    failed = 1;
                    if (mismatch_cnt < 10)
                        $display("mismatch: expected %p actual %p", want, got);
                    mismatch_cnt++;
                end
            end
        end
    end

    function automatic logic signed [31:0] near_value();
        return 32'($signed($urandom_range(0, 80)) - 40);
    endfunction

    task automatic test_extremes();
        send_request(KIND_RANK, 0, 0);
        send_request(KIND_ERASE, 5, 0);
        send_request(KIND_INSERT, 32'sh80000000, 0);
        send_request(KIND_INSERT, 32'sh7fffffff, 0);
        send_request(KIND_INSERT, 32'sh80000000, 0);
        send_request(KIND_CONTAINS, 32'sh80000000, 0);
        send_request(KIND_CONTAINS, 32'sh80000001, 0);
        send_request(KIND_RANK, 0, 1);
        send_request(KIND_RANK, 0, 32'hffffffff);
        send_request(KIND_ERASE, 32'sh7fffffff, 0);
        send_request(KIND_ERASE, 32'sh80000000, 0);
    endtask

    task automatic test_merge_split();
        send_request(KIND_INSERT, 10, 0);
        send_request(KIND_INSERT, 12, 0);
        send_request(KIND_INSERT, 11, 0);
        send_request(KIND_INSERT, 9, 0);
        send_request(KIND_ERASE, 11, 0);
        send_request(KIND_ERASE, 9, 0);
        send_request(KIND_ERASE, 12, 0);
        send_request(KIND_RANK, 0, 1);
        send_request(KIND_ERASE, 10, 0);
    endtask

    task automatic test_store_full();
        for (int k = 0; k < CAP; k++) send_request(KIND_INSERT, 32'(3 * k), 0);
        send_request(KIND_INSERT, 100, 0);
        send_request(KIND_INSERT, 1, 0);
        for (int k = 0; k < CAP; k++) send_request(KIND_ERASE, 32'(3 * k), 0);
    endtask

    // Whole range in one interval: built by inserts near both ends is too slow,
    // so instead fill from the extremes only a few points; 2^32 is reachable only
    // by filling every value, which is out of reach, so widths stay wide elsewhere.
    task automatic test_random(int n);
        logic [1:0] kind;
        logic signed [31:0] v;
        logic [31:0] r;
        for (int i = 0; i < n; i++) begin
            kind = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: v = $urandom();
                1: v = ($urandom_range(0, 1)) ? 32'sh7fffffff - $urandom_range(0, 3)
                                              : 32'sh80000000 + $urandom_range(0, 3);
                default: v = near_value();
            endcase
            r = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 90);
            send_request(kind, v, r);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_kind  <= KIND_INSERT;
        i_value <= '0;
        i_rank  <= '0;
        cycle_cnt = 0;
        span_cnt = 0;
        elem_cnt = 0;
        failed = 0;
        mismatch_cnt = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_merge_split();
        test_store_full();
        test_random(1800);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (failed == 0 && pending_results.size() == 0) begin
            $display("tb_interval_set_point_update_core: done, clean");
        end else begin
            $display("tb_interval_set_point_update_core: done, errors");
        end
        $finish;
    end
endmodule
